// ===== rtl/caspid_pkg.sv =====
// Shared types, constants and tables for the cascaded angle and speed PID block.
`default_nettype none

package caspid_pkg;

  // Fixed-point format of signals and gains.
  localparam int unsigned FracBits = 16;

  // Field and register widths.
  localparam int unsigned DataW = 32;
  localparam int unsigned LimW  = 31;
  localparam int unsigned RpmW  = 16;
  localparam int unsigned CmdW  = 16;
  localparam int unsigned IdxW  = 4;
  localparam int unsigned InW   = 2 * DataW + RpmW;

  // Output saturation bound of the current command.
  localparam int unsigned CmdMax = 16384;

  // Speed feedback is rpm * 2^FbShift / 15; its magnitude stays below 2^(FbW-1).
  localparam int unsigned FbShift = 11 + FracBits;
  localparam int unsigned FbW     = 24 + FracBits;

  // Exact quotient by 15 for any 16-bit magnitude: (x * Recip15) >> RecipShift.
  localparam int unsigned RecipShift = 20;
  localparam int unsigned QuoW       = 12;
  localparam logic signed [DataW-1:0] Recip15 = 32'sd69906;

  // Product and accumulator widths.
  localparam int unsigned ProdW = 2 * DataW;
  localparam int unsigned TermW = ProdW - FracBits;
  localparam int unsigned SumW  = TermW + 2;

  // Register reset values.
  localparam logic signed [DataW-1:0] AngleKdRst  = 32'sd6554;
  localparam logic [LimW-1:0]         AngleLimRst = 31'd524288000;
  localparam logic signed [DataW-1:0] SpeedKpRst  = 32'sd655360;
  localparam logic signed [DataW-1:0] SpeedKiRst  = 32'sd32768;
  localparam logic [LimW-1:0]         SpeedLimRst = 31'd1048576000;

  typedef enum logic [IdxW-1:0] {
    REG_ANGLE_KP    = 4'd0,
    REG_ANGLE_KI    = 4'd1,
    REG_ANGLE_KD    = 4'd2,
    REG_ANGLE_LIMIT = 4'd3,
    REG_SPEED_KP    = 4'd4,
    REG_SPEED_KI    = 4'd5,
    REG_SPEED_KD    = 4'd6,
    REG_SPEED_LIMIT = 4'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AERR,
    S_AP,
    S_AI,
    S_AD,
    S_AOUT,
    S_SERR,
    S_SP,
    S_SI,
    S_SD,
    S_SOUT,
    S_CMD
  } state_e;

  // Operands of one error, integral and derivative update.
  typedef struct packed {
    logic signed [FbW-1:0]   target;
    logic signed [FbW-1:0]   measured;
    logic signed [DataW-1:0] integ;
    logic signed [DataW-1:0] last;
    logic [LimW-1:0]         lim;
  } err_arg_t;

  typedef struct packed {
    logic signed [DataW-1:0] err;
    logic signed [DataW-1:0] acc;
    logic signed [DataW-1:0] der;
  } err_res_t;

  // floor(r * 2^FbShift / 15) for a remainder r of a division by 15.
  function automatic logic [FbShift-1:0] fb_frac(input logic [3:0] r);
    logic [FbShift-1:0] v;
    case (r)
      4'd1:    v = FbShift'((64'd1 << FbShift) / 64'd15);
      4'd2:    v = FbShift'((64'd2 << FbShift) / 64'd15);
      4'd3:    v = FbShift'((64'd3 << FbShift) / 64'd15);
      4'd4:    v = FbShift'((64'd4 << FbShift) / 64'd15);
      4'd5:    v = FbShift'((64'd5 << FbShift) / 64'd15);
      4'd6:    v = FbShift'((64'd6 << FbShift) / 64'd15);
      4'd7:    v = FbShift'((64'd7 << FbShift) / 64'd15);
      4'd8:    v = FbShift'((64'd8 << FbShift) / 64'd15);
      4'd9:    v = FbShift'((64'd9 << FbShift) / 64'd15);
      4'd10:   v = FbShift'((64'd10 << FbShift) / 64'd15);
      4'd11:   v = FbShift'((64'd11 << FbShift) / 64'd15);
      4'd12:   v = FbShift'((64'd12 << FbShift) / 64'd15);
      4'd13:   v = FbShift'((64'd13 << FbShift) / 64'd15);
      4'd14:   v = FbShift'((64'd14 << FbShift) / 64'd15);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cascade_angle_speed_pid.sv =====
// Top level of the cascaded angle and speed PID current controller.
//
// One input beat on the s_axis channel carries a control tick: target angle,
// measured angle (both Q16.16 degrees) and motor speed in rpm. The outer angle
// loop produces a speed setpoint; the inner speed loop compares it against the
// speed feedback rpm * 8192 / 60 and produces a current command that is
// truncated toward zero and saturated to plus or minus 16384. Exactly one
// output beat on the m_axis channel follows each input beat.
// The sequencer takes one step per product term on the single shared 32x32
// multiplier, plus the two error updates, the two output clamps and the final
// command step; the feedback scaling overlaps the angle error step. The input
// is ready only while idle, so a new tick waits for the last one; it is ready
// again in the cycle the command appears. A finished command sits in an output
// register; the next tick is accepted while it waits, and the sequencer only
// holds at its last step when that register is still full. A stalled receiver
// therefore stalls the input after at most one further tick. Reset clears both
// loops' integrals and previous errors, loads the default gains and limits,
// and empties the output register. Gains and limits are to be written
// through the cfg port only while the block is idle; this is not enforced.
`default_nettype none

module cascade_angle_speed_pid (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input beat: target_angle [31:0], measured_angle [63:32], shaft_rpm [79:64].
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [caspid_pkg::InW-1:0]         s_axis_tdata_i,
  // Output beat: drive_current [15:0].
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [caspid_pkg::CmdW-1:0]        m_axis_tdata_o,
  // Register write port.
  input  logic                               cfg_we_i,
  input  logic [caspid_pkg::IdxW-1:0]        cfg_index_i,
  input  logic [caspid_pkg::DataW-1:0]       cfg_data_i
);
  import caspid_pkg::*;

  state_e state_q, state_d;

  // Gains and limits.
  logic signed [DataW-1:0] angle_kp_q, angle_ki_q, angle_kd_q;
  logic signed [DataW-1:0] speed_kp_q, speed_ki_q, speed_kd_q;
  logic [LimW-1:0]         angle_limit_q, speed_limit_q;

  // Loop state.
  logic signed [DataW-1:0] angle_int_q, angle_last_q;
  logic signed [DataW-1:0] speed_int_q, speed_last_q;

  // Working registers of one tick.
  logic signed [DataW-1:0] tgt_q, meas_q;
  logic signed [RpmW-1:0]  rpm_q;
  logic signed [DataW-1:0] err_q, acc_q, der_q;
  logic signed [FbW-1:0]   fb_q;
  logic signed [SumW-1:0]  sum_q;
  logic signed [DataW-1:0] sp_q, so_q;

  logic                    out_valid_q;
  logic [CmdW-1:0]         out_data_q;

  // Shared units.
  logic signed [DataW-1:0] mul_a, mul_b;
  logic signed [ProdW-1:0] prod;
  err_arg_t                err_arg;
  err_res_t                err_res;

  // Datapath terms.
  logic                    in_fire;
  logic                    out_load;
  logic [RpmW:0]           rpm_abs;
  logic [RpmW-1:0]         rpm_mag;
  logic [QuoW-1:0]         quo;
  logic [RpmW-1:0]         rem_full;
  logic [FbW-2:0]          fb_mag;
  logic signed [FbW-1:0]   fb_next;
  logic signed [TermW-1:0] term;
  logic signed [SumW-1:0]  term_ext;
  logic signed [SumW-1:0]  sum_tot;
  logic [DataW:0]          so_abs;
  logic [DataW:0]          cmd_abs;
  logic [CmdW-1:0]         cmd_sat;
  logic [CmdW-1:0]         cmd;

  // Clamp an accumulated sum to plus or minus the loop limit.
  function automatic logic signed [DataW-1:0] clamp_lim(input logic signed [SumW-1:0] v,
                                                         input logic [LimW-1:0] lim);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    logic signed [DataW-1:0] r;
    hi = $signed(SumW'(lim));
    lo = -hi;
    if (v > hi) begin
      r = hi[DataW-1:0];
    end else if (v < lo) begin
      r = lo[DataW-1:0];
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

  caspid_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  caspid_err u_err (
    .arg_i (err_arg),
    .res_o (err_res)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (s_axis_tvalid_i) state_d = S_AERR;
      S_AERR:  state_d = S_AP;
      S_AP:    state_d = S_AI;
      S_AI:    state_d = S_AD;
      S_AD:    state_d = S_AOUT;
      S_AOUT:  state_d = S_SERR;
      S_SERR:  state_d = S_SP;
      S_SP:    state_d = S_SI;
      S_SI:    state_d = S_SD;
      S_SD:    state_d = S_SOUT;
      S_SOUT:  state_d = S_CMD;
      S_CMD:   if (!out_valid_q || m_axis_tready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Operand selection for the shared multiplier and error unit.
  always_comb begin
    mul_a            = '0;
    mul_b            = '0;
    err_arg.target   = FbW'(tgt_q);
    err_arg.measured = FbW'(meas_q);
    err_arg.integ    = angle_int_q;
    err_arg.last     = angle_last_q;
    err_arg.lim      = angle_limit_q;
    out_load         = 1'b0;
    case (state_q)
      S_AERR: begin
        mul_a = $signed(DataW'(rpm_mag));
        mul_b = Recip15;
      end
      S_AP: begin
        mul_a = angle_kp_q;
        mul_b = err_q;
      end
      S_AI: begin
        mul_a = angle_ki_q;
        mul_b = acc_q;
      end
      S_AD: begin
        mul_a = angle_kd_q;
        mul_b = der_q;
      end
      S_SERR: begin
        err_arg.target   = FbW'(sp_q);
        err_arg.measured = fb_q;
        err_arg.integ    = speed_int_q;
        err_arg.last     = speed_last_q;
        err_arg.lim      = speed_limit_q;
      end
      S_SP: begin
        mul_a = speed_kp_q;
        mul_b = err_q;
      end
      S_SI: begin
        mul_a = speed_ki_q;
        mul_b = acc_q;
      end
      S_SD: begin
        mul_a = speed_kd_q;
        mul_b = der_q;
      end
      S_CMD:   out_load = !out_valid_q || m_axis_tready_i;
      default: ;
    endcase
  end

  // Speed feedback: |rpm| = 15 * quo + rem, so the scaled value is
  // quo * 2^FbShift plus a table entry for the remainder.
  always_comb begin
    rpm_abs  = rpm_q[RpmW-1] ? -{rpm_q[RpmW-1], rpm_q} : {rpm_q[RpmW-1], rpm_q};
    rpm_mag  = rpm_abs[RpmW-1:0];
    quo      = prod[RecipShift +: QuoW];
    rem_full = rpm_mag - (RpmW'({quo, 4'b0000}) - RpmW'(quo));
    fb_mag   = ((FbW-1)'(quo) << FbShift) + (FbW-1)'(fb_frac(rem_full[3:0]));
    fb_next  = rpm_q[RpmW-1] ? -$signed({1'b0, fb_mag}) : $signed({1'b0, fb_mag});
  end

  // Product term, floored by the arithmetic shift, and the running sum.
  always_comb begin
    term     = prod[ProdW-1:FracBits];
    term_ext = SumW'(term);
    sum_tot  = sum_q + term_ext;
  end

  // Truncate the speed output toward zero and saturate it.
  always_comb begin
    so_abs  = so_q[DataW-1] ? -{so_q[DataW-1], so_q} : {so_q[DataW-1], so_q};
    cmd_abs = so_abs >> FracBits;
    cmd_sat = (cmd_abs > (DataW+1)'(CmdMax)) ? CmdW'(CmdMax) : cmd_abs[CmdW-1:0];
    cmd     = so_q[DataW-1] ? -cmd_sat : cmd_sat;
  end

  // Control state, registers and loop state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      angle_kp_q    <= '0;
      angle_ki_q    <= '0;
      angle_kd_q    <= AngleKdRst;
      angle_limit_q <= AngleLimRst;
      speed_kp_q    <= SpeedKpRst;
      speed_ki_q    <= SpeedKiRst;
      speed_kd_q    <= '0;
      speed_limit_q <= SpeedLimRst;
      angle_int_q   <= '0;
      angle_last_q  <= '0;
      speed_int_q   <= '0;
      speed_last_q  <= '0;
    end else begin
      state_q <= state_d;

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      if (state_q == S_AERR) begin
        angle_int_q  <= err_res.acc;
        angle_last_q <= err_res.err;
      end
      if (state_q == S_SERR) begin
        speed_int_q  <= err_res.acc;
        speed_last_q <= err_res.err;
      end

      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_ANGLE_KP:    angle_kp_q    <= cfg_data_i;
          REG_ANGLE_KI:    angle_ki_q    <= cfg_data_i;
          REG_ANGLE_KD:    angle_kd_q    <= cfg_data_i;
          REG_ANGLE_LIMIT: angle_limit_q <= cfg_data_i[LimW-1:0];
          REG_SPEED_KP:    speed_kp_q    <= cfg_data_i;
          REG_SPEED_KI:    speed_ki_q    <= cfg_data_i;
          REG_SPEED_KD:    speed_kd_q    <= cfg_data_i;
          REG_SPEED_LIMIT: speed_limit_q <= cfg_data_i[LimW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Working registers of the current tick.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      tgt_q  <= s_axis_tdata_i[DataW-1:0];
      meas_q <= s_axis_tdata_i[2*DataW-1:DataW];
      rpm_q  <= s_axis_tdata_i[InW-1:2*DataW];
    end
    if (state_q == S_AERR || state_q == S_SERR) begin
      err_q <= err_res.err;
      acc_q <= err_res.acc;
      der_q <= err_res.der;
    end
    if (state_q == S_AP) begin
      fb_q <= fb_next;
    end
    if (state_q == S_AI || state_q == S_SI) begin
      sum_q <= term_ext;
    end
    if (state_q == S_AD || state_q == S_SD) begin
      sum_q <= sum_tot;
    end
    if (state_q == S_AOUT) begin
      sp_q <= clamp_lim(sum_tot, angle_limit_q);
    end
    if (state_q == S_SOUT) begin
      so_q <= clamp_lim(sum_tot, speed_limit_q);
    end
    if (out_load) begin
      out_data_q <= cmd;
    end
  end

`ifndef SYNTHESIS
  // An accepted tick always starts with the angle error step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_AERR)
    else $error("accepted tick did not start the angle loop");

  // A command stays in the last step while the output register is blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMD && out_valid_q && !m_axis_tready_i) |=> state_q == S_CMD)
    else $error("command step left while the output was blocked");

  // The command on the output never leaves the saturation range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(m_axis_tdata_o) <= $signed(CmdW'(CmdMax)) &&
                         $signed(m_axis_tdata_o) >= -$signed(CmdW'(CmdMax))))
    else $error("drive current outside the saturation range");

  // Each loop's integral is inside its limit right after its update.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_AP |->
      ($signed({angle_int_q[DataW-1], angle_int_q}) <= $signed({2'b00, angle_limit_q}) &&
       $signed({angle_int_q[DataW-1], angle_int_q}) >= -$signed({2'b00, angle_limit_q})))
    else $error("angle integral beyond its limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SP |->
      ($signed({speed_int_q[DataW-1], speed_int_q}) <= $signed({2'b00, speed_limit_q}) &&
       $signed({speed_int_q[DataW-1], speed_int_q}) >= -$signed({2'b00, speed_limit_q})))
    else $error("speed integral beyond its limit");
`endif

endmodule

`default_nettype wire

// ===== rtl/caspid_mul.sv =====
// Shared signed 32x32 multiplier with a registered product.
`default_nettype none

module caspid_mul (
  input  logic                                   clk_i,
  input  logic signed [caspid_pkg::DataW-1:0]    a_i,
  input  logic signed [caspid_pkg::DataW-1:0]    b_i,
  output logic signed [caspid_pkg::ProdW-1:0]    prod_o
);
  import caspid_pkg::*;

  always_ff @(posedge clk_i) begin
    prod_o <= a_i * b_i;
  end

endmodule

`default_nettype wire

// ===== rtl/caspid_err.sv =====
// Error, clamped integral and derivative update shared by both PID loops.
`default_nettype none

module caspid_err (
  input  caspid_pkg::err_arg_t arg_i,
  output caspid_pkg::err_res_t res_o
);
  import caspid_pkg::*;

  logic signed [FbW:0]   diff;
  logic signed [DataW:0] acc_sum;
  logic signed [DataW:0] der_sum;
  logic signed [DataW:0] lim_pos;
  logic signed [DataW:0] lim_neg;

  // Saturate a wide signed value to the 32-bit signed range.
  function automatic logic signed [DataW-1:0] sat_data(input logic signed [FbW:0] v);
    logic signed [DataW-1:0] r;
    if (v[FbW:DataW-1] == '0 || v[FbW:DataW-1] == '1) begin
      r = v[DataW-1:0];
    end else if (v[FbW]) begin
      r = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      r = {1'b0, {(DataW-1){1'b1}}};
    end
    return r;
  endfunction

  always_comb begin
    diff      = {arg_i.target[FbW-1], arg_i.target} - {arg_i.measured[FbW-1], arg_i.measured};
    res_o.err = sat_data(diff);

    lim_pos = $signed({2'b00, arg_i.lim});
    lim_neg = -lim_pos;
    acc_sum = {arg_i.integ[DataW-1], arg_i.integ} + {res_o.err[DataW-1], res_o.err};
    if (acc_sum > lim_pos) begin
      res_o.acc = lim_pos[DataW-1:0];
    end else if (acc_sum < lim_neg) begin
      res_o.acc = lim_neg[DataW-1:0];
    end else begin
      res_o.acc = acc_sum[DataW-1:0];
    end

    der_sum   = {res_o.err[DataW-1], res_o.err} - {arg_i.last[DataW-1], arg_i.last};
    res_o.der = sat_data((FbW+1)'(der_sum));
  end

endmodule

`default_nettype wire
